// ===== hw/rtl/dmd_pkg.sv =====
// Shared constants and types for the dual maglev derivative pipeline.
// Depends on nothing; used by dmd_div and dual_maglev_derivative.
package dmd_pkg;

	localparam int DATA_W    = 48;
	localparam int FRAC_W    = 24;
	// Gap floor of one micrometer, rounded to the data format.
	localparam int GAP_FLOOR = ((1 << FRAC_W) + 500000) / 1000000;

	// Shared divider geometry: every lane divides a NUM_W-bit magnitude by a
	// DEN_W-bit magnitude and produces QUO_W quotient bits plus an overflow mark.
	localparam int NUM_W = 143;
	localparam int DEN_W = 119;
	localparam int QUO_W = 75;
	localparam int LANES = 6;

	// Lane groups; ball two sits at the group base plus one.
	localparam int LANE_MAG = 0;
	localparam int LANE_CPL = 2;
	localparam int LANE_SLP = 4;

	typedef enum logic [2:0] {
		REG_MASS_ONE      = 3'd0,
		REG_MASS_TWO      = 3'd1,
		REG_GRAVITY       = 3'd2,
		REG_RESIST_ONE    = 3'd3,
		REG_RESIST_TWO    = 3'd4,
		REG_INDUCTANCE    = 3'd5,
		REG_FORCE_CONST   = 3'd6,
		REG_COUPLING_GAIN = 3'd7
	} cfg_idx_t;

	typedef struct packed {
		logic             neg;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [QUO_W-1:0] quo;
	} div_res_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] spd_two;
		logic signed [DATA_W-1:0] spd_one;
	} side_t;

endpackage

// ===== hw/rtl/dmd_div.sv =====
// Six-lane pipelined restoring divider, one quotient bit per stage.
// Depends on dmd_pkg for widths and the request, result and side types.
module dmd_div (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              adv,
	input  logic              in_valid,
	input  dmd_pkg::div_req_t in_req [dmd_pkg::LANES],
	input  dmd_pkg::side_t    in_side,
	output logic              out_valid,
	output dmd_pkg::div_res_t out_res [dmd_pkg::LANES],
	output dmd_pkg::side_t    out_side
);

	typedef struct packed {
		logic                      neg;
		logic                      ovf;
		logic [dmd_pkg::DEN_W-1:0] den;
		logic [dmd_pkg::DEN_W-1:0] rem;
		logic [dmd_pkg::QUO_W-1:0] sh;
	} stage_t;

	// Numerator bits leave the top of sh while quotient bits enter at the bottom.
	function automatic stage_t div_step(input stage_t x);
		stage_t                  r;
		logic [dmd_pkg::DEN_W:0] t;
		logic [dmd_pkg::DEN_W:0] d;
		logic                    ge;
		r     = x;
		t     = {x.rem, x.sh[dmd_pkg::QUO_W-1]};
		d     = {1'b0, x.den};
		ge    = (t >= d);
		r.rem = ge ? dmd_pkg::DEN_W'(t - d) : t[dmd_pkg::DEN_W-1:0];
		r.sh  = {x.sh[dmd_pkg::QUO_W-2:0], ge};
		return r;
	endfunction

	logic           vld_s  [0:dmd_pkg::QUO_W];
	dmd_pkg::side_t side_s [0:dmd_pkg::QUO_W];
	stage_t         lane_s [0:dmd_pkg::QUO_W][dmd_pkg::LANES];
	stage_t         entry_w [dmd_pkg::LANES];

	// A quotient that would not fit in QUO_W bits is flagged up front.
	always_comb begin
		for (int l = 0; l < dmd_pkg::LANES; l++) begin
			entry_w[l].neg = in_req[l].neg;
			entry_w[l].den = in_req[l].den;
			entry_w[l].rem = dmd_pkg::DEN_W'(in_req[l].num[dmd_pkg::NUM_W-1:dmd_pkg::QUO_W]);
			entry_w[l].ovf = (dmd_pkg::DEN_W'(in_req[l].num[dmd_pkg::NUM_W-1:dmd_pkg::QUO_W])
				>= in_req[l].den);
			entry_w[l].sh  = in_req[l].num[dmd_pkg::QUO_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k <= dmd_pkg::QUO_W; k++) vld_s[k] <= 1'b0;
		end else if (adv) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k <= dmd_pkg::QUO_W; k++) vld_s[k] <= vld_s[k-1];
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			side_s[0] <= in_side;
			for (int l = 0; l < dmd_pkg::LANES; l++) lane_s[0][l] <= entry_w[l];
			for (int k = 1; k <= dmd_pkg::QUO_W; k++) begin
				side_s[k] <= side_s[k-1];
				for (int l = 0; l < dmd_pkg::LANES; l++) begin
					lane_s[k][l] <= div_step(lane_s[k-1][l]);
				end
			end
		end
	end

	assign out_valid = vld_s[dmd_pkg::QUO_W];
	assign out_side  = side_s[dmd_pkg::QUO_W];

	always_comb begin
		for (int l = 0; l < dmd_pkg::LANES; l++) begin
			out_res[l].neg = lane_s[dmd_pkg::QUO_W][l].neg;
			out_res[l].ovf = lane_s[dmd_pkg::QUO_W][l].ovf;
			out_res[l].quo = lane_s[dmd_pkg::QUO_W][l].sh;
		end
	end

endmodule

// ===== hw/rtl/dual_maglev_derivative.sv =====
// Top level of the two-ball magnetic levitation derivative pipeline.
// Depends on dmd_pkg (constants, types) and dmd_div (six-lane divider).
//
//  Channel   | Direction | Handshake           | Content
//  ----------+-----------+---------------------+-------------------------------------------
//  cfg       | in        | cfg_we              | register index and write data, no read-back
//  s (input) | in        | s_tvalid / s_tready | eight 48-bit state and voltage fields
//  m (output)| out       | m_tvalid / m_tready | six 48-bit derivatives and the clip flag
//
// Every request passes six front stages (gap floor, products and sums), one divider entry
// stage, 75 divider stages (one quotient bit each, set by the 75-bit quotient of the
// shared divider) and three stages for signs, sums and saturation, ending in the output
// register. A new request is accepted every cycle while the output is not stalled.
// Reset clears the valid bits and loads the default register values.
// A stall on the output freezes every stage at once, so nothing is lost or repeated.
module dual_maglev_derivative (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [40:0]  cfg_data,
	input  logic         s_tvalid,
	output logic         s_tready,
	// gap_one, speed_one, current_one, gap_two, speed_two, current_two,
	// voltage_one, voltage_two (48 bits each, lowest bits first)
	input  logic [383:0] s_tdata,
	output logic         m_tvalid,
	input  logic         m_tready,
	// rate_gap_one, accel_one, rate_current_one, rate_gap_two, accel_two,
	// rate_current_two (48 bits each), clipped (1 bit), then 7 zero bits
	output logic [295:0] m_tdata
);

	typedef struct packed {
		logic signed [47:0] voltage_two;
		logic signed [47:0] voltage_one;
		logic signed [47:0] current_two;
		logic signed [47:0] speed_two;
		logic signed [47:0] gap_two;
		logic signed [47:0] current_one;
		logic signed [47:0] speed_one;
		logic signed [47:0] gap_one;
	} in_t;

	typedef struct packed {
		logic [6:0]         pad;
		logic               clipped;
		logic signed [47:0] rate_current_two;
		logic signed [47:0] accel_two;
		logic signed [47:0] rate_gap_two;
		logic signed [47:0] rate_current_one;
		logic signed [47:0] accel_one;
		logic signed [47:0] rate_gap_one;
	} out_t;

	// Saturates a wide signed sum to the 48-bit data range; the top bit of the
	// result marks that clipping happened.
	function automatic logic [48:0] sat_w(input logic signed [77:0] x);
		logic fits;
		fits = (x[77:47] == '0) || (x[77:47] == '1);
		if (fits) return {1'b0, x[47:0]};
		else if (x[77]) return {1'b1, 1'b1, 47'd0};
		else return {1'b1, 1'b0, {47{1'b1}}};
	endfunction

	// ------------------------------------------------------------------
	// Configuration registers. Writes only happen while the pipeline is empty: the user must
	// keep to this, the block does not enforce it, and every stage reads them directly.
	// ------------------------------------------------------------------
	logic [24:0] mass_q [2];
	logic [28:0] gravity_q;
	logic [30:0] res_q [2];
	logic [24:0] ind_q;
	logic [40:0] fc_q;
	logic [24:0] kc_q;
	logic [24:0] mass_eff [2];
	logic [24:0] ind_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mass_q[0] <= 25'd838861;
			mass_q[1] <= 25'd838861;
			gravity_q <= 29'd164584489;
			res_q[0]  <= 31'd167772160;
			res_q[1]  <= 31'd167772160;
			ind_q     <= 25'd1677722;
			fc_q      <= 41'd109951163;
			kc_q      <= 25'd167772;
		end else if (cfg_we) begin
			unique case (dmd_pkg::cfg_idx_t'(cfg_index))
				dmd_pkg::REG_MASS_ONE:      mass_q[0] <= cfg_data[24:0];
				dmd_pkg::REG_MASS_TWO:      mass_q[1] <= cfg_data[24:0];
				dmd_pkg::REG_GRAVITY:       gravity_q <= cfg_data[28:0];
				dmd_pkg::REG_RESIST_ONE:    res_q[0]  <= cfg_data[30:0];
				dmd_pkg::REG_RESIST_TWO:    res_q[1]  <= cfg_data[30:0];
				dmd_pkg::REG_INDUCTANCE:    ind_q     <= cfg_data[24:0];
				dmd_pkg::REG_FORCE_CONST:   fc_q      <= cfg_data;
				dmd_pkg::REG_COUPLING_GAIN: kc_q      <= cfg_data[24:0];
			endcase
		end
	end

	// A zero mass or inductance behaves as one LSB so the divisor is never zero.
	always_comb begin
		for (int b = 0; b < 2; b++) mass_eff[b] = (mass_q[b] == '0) ? 25'd1 : mass_q[b];
		ind_eff = (ind_q == '0) ? 25'd1 : ind_q;
	end

	// ------------------------------------------------------------------
	// Global stall: all stages move together whenever the output register
	// is empty or being drained.
	// ------------------------------------------------------------------
	logic adv;
	logic vld_s1, vld_s2, vld_s3, vld_s4, vld_s5, vld_s6, vld_s7, vld_s8, vld_s9;
	logic div_vld;

	assign adv      = !vld_s9 || m_tready;
	assign s_tready = adv;

	// ------------------------------------------------------------------
	// Stage 1: gap floor and current magnitude.
	// ------------------------------------------------------------------
	in_t                in_w;
	logic signed [47:0] gap_w [2];
	logic signed [47:0] cur_w [2];
	logic signed [47:0] volt_w [2];
	logic [46:0]        flr_w [2];
	logic [47:0]        imag_w [2];

	assign in_w = in_t'(s_tdata);

	always_comb begin
		gap_w[0]  = in_w.gap_one;
		gap_w[1]  = in_w.gap_two;
		cur_w[0]  = in_w.current_one;
		cur_w[1]  = in_w.current_two;
		volt_w[0] = in_w.voltage_one;
		volt_w[1] = in_w.voltage_two;
		for (int b = 0; b < 2; b++) begin
			// Negative gaps and gaps under one micrometer are clamped to the floor.
			if (gap_w[b][47] || ($unsigned(gap_w[b]) < 48'(dmd_pkg::GAP_FLOOR))) begin
				flr_w[b] = 47'(dmd_pkg::GAP_FLOOR);
			end else begin
				flr_w[b] = gap_w[b][46:0];
			end
			imag_w[b] = cur_w[b][47] ? (48'd0 - cur_w[b]) : cur_w[b];
		end
	end

	logic [46:0]        y_s1 [2];
	logic [47:0]        imag_s1 [2];
	logic               ineg_s1 [2];
	logic signed [47:0] volt_s1 [2];
	dmd_pkg::side_t     side_s1;

	// Stage 2 registers: 24-bit chunk products for the squares and R*|i|.
	logic [47:0]        isq_ll_s2 [2];
	logic [47:0]        isq_lh_s2 [2];
	logic [47:0]        isq_hh_s2 [2];
	logic [47:0]        ysq_ll_s2 [2];
	logic [47:0]        ysq_lh_s2 [2];
	logic [47:0]        ysq_hh_s2 [2];
	logic [54:0]        ri_lo_s2 [2];
	logic [54:0]        ri_hi_s2 [2];
	logic signed [47:0] diff_s2;
	logic               ineg_s2 [2];
	logic signed [47:0] volt_s2 [2];
	dmd_pkg::side_t     side_s2;

	// Stage 3 registers: full squares, R*|i| and the spring stretch magnitude.
	logic [95:0]        isq_s3 [2];
	logic [95:0]        ysq_s3 [2];
	logic [78:0]        ri_s3 [2];
	logic [47:0]        dmag_s3;
	logic               dneg_s3;
	logic               ineg_s3 [2];
	logic signed [47:0] volt_s3 [2];
	dmd_pkg::side_t     side_s3;

	// Stage 4 registers: partial products of C*i^2, y^2*m and kc*dy; slope numerator.
	logic [47:0]        npp_s4 [2][2][4];
	logic [48:0]        dpp_s4 [2][4];
	logic [48:0]        spp_s4 [2];
	logic               dneg_s4;
	logic signed [80:0] slope_s4 [2];
	dmd_pkg::side_t     side_s4;

	// Stage 5 registers.
	logic [119:0]       nh_w [2][2];
	logic [118:0]       d_w [2];
	logic [119:0]       nh_s5 [2][2];
	logic [118:0]       d_s5 [2];
	logic [71:0]        spring_s5;
	logic               spneg_s5;
	logic [79:0]        slmag_s5 [2];
	logic               slneg_s5 [2];
	dmd_pkg::side_t     side_s5;

	// Stage 6 registers: divider operands.
	logic [134:0]       n_s6 [2];
	logic [118:0]       d_s6 [2];
	logic [71:0]        spring_s6;
	logic               spneg_s6;
	logic [79:0]        slmag_s6 [2];
	logic               slneg_s6 [2];
	dmd_pkg::side_t     side_s6;

	// Each half of C*i^2 and the y^2*m product are summed from shifted chunks.
	always_comb begin
		for (int b = 0; b < 2; b++) begin
			for (int k = 0; k < 2; k++) begin
				nh_w[b][k] = '0;
				for (int j = 0; j < 4; j++) begin
					nh_w[b][k] = nh_w[b][k] + (120'(npp_s4[b][k][j]) << (24 * j));
				end
			end
			d_w[b] = '0;
			for (int j = 0; j < 4; j++) begin
				d_w[b] = d_w[b] + (119'(dpp_s4[b][j]) << (24 * j));
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= s_tvalid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			// Stage 1
			for (int b = 0; b < 2; b++) begin
				y_s1[b]    <= flr_w[b];
				imag_s1[b] <= imag_w[b];
				ineg_s1[b] <= cur_w[b][47];
				volt_s1[b] <= volt_w[b];
			end
			side_s1.spd_one <= in_w.speed_one;
			side_s1.spd_two <= in_w.speed_two;

			// Stage 2: the cross term of each square is formed once and doubled later.
			for (int b = 0; b < 2; b++) begin
				isq_ll_s2[b] <= 48'(imag_s1[b][23:0]) * 48'(imag_s1[b][23:0]);
				isq_lh_s2[b] <= 48'(imag_s1[b][23:0]) * 48'(imag_s1[b][47:24]);
				isq_hh_s2[b] <= 48'(imag_s1[b][47:24]) * 48'(imag_s1[b][47:24]);
				ysq_ll_s2[b] <= 48'(y_s1[b][23:0]) * 48'(y_s1[b][23:0]);
				ysq_lh_s2[b] <= 48'(y_s1[b][23:0]) * 48'(y_s1[b][46:24]);
				ysq_hh_s2[b] <= 48'(y_s1[b][46:24]) * 48'(y_s1[b][46:24]);
				ri_lo_s2[b]  <= 55'(res_q[b]) * 55'(imag_s1[b][23:0]);
				ri_hi_s2[b]  <= 55'(res_q[b]) * 55'(imag_s1[b][47:24]);
				ineg_s2[b]   <= ineg_s1[b];
				volt_s2[b]   <= volt_s1[b];
			end
			diff_s2 <= $signed({1'b0, y_s1[1]}) - $signed({1'b0, y_s1[0]});
			side_s2 <= side_s1;

			// Stage 3
			for (int b = 0; b < 2; b++) begin
				isq_s3[b]  <= (96'(isq_hh_s2[b]) << 48) + (96'(isq_lh_s2[b]) << 25)
					+ 96'(isq_ll_s2[b]);
				ysq_s3[b]  <= (96'(ysq_hh_s2[b]) << 48) + (96'(ysq_lh_s2[b]) << 25)
					+ 96'(ysq_ll_s2[b]);
				ri_s3[b]   <= (79'(ri_hi_s2[b]) << 24) + 79'(ri_lo_s2[b]);
				ineg_s3[b] <= ineg_s2[b];
				volt_s3[b] <= volt_s2[b];
			end
			dneg_s3 <= diff_s2[47];
			dmag_s3 <= diff_s2[47] ? 48'(-diff_s2) : 48'(diff_s2);
			side_s3 <= side_s2;

			// Stage 4: the slope numerator is V*2^24 - R*i with the sign of i folded in.
			for (int b = 0; b < 2; b++) begin
				for (int j = 0; j < 4; j++) begin
					npp_s4[b][0][j] <= 48'(fc_q[23:0]) * 48'(isq_s3[b][24*j +: 24]);
					npp_s4[b][1][j] <= 48'(fc_q[40:24]) * 48'(isq_s3[b][24*j +: 24]);
					dpp_s4[b][j]    <= 49'(mass_eff[b]) * 49'(ysq_s3[b][24*j +: 24]);
				end
				slope_s4[b] <= ineg_s3[b] ? ((81'(volt_s3[b]) <<< 24) + 81'(ri_s3[b]))
					: ((81'(volt_s3[b]) <<< 24) - 81'(ri_s3[b]));
			end
			for (int j = 0; j < 2; j++) begin
				spp_s4[j] <= 49'(kc_q) * 49'(dmag_s3[24*j +: 24]);
			end
			dneg_s4 <= dneg_s3;
			side_s4 <= side_s3;

			// Stage 5
			for (int b = 0; b < 2; b++) begin
				nh_s5[b]    <= nh_w[b];
				d_s5[b]     <= d_w[b];
				slneg_s5[b] <= slope_s4[b][80];
				slmag_s5[b] <= slope_s4[b][80] ? 80'(-slope_s4[b]) : 80'(slope_s4[b]);
			end
			spring_s5 <= (72'(spp_s4[1]) << 24) + 72'(spp_s4[0]);
			spneg_s5  <= dneg_s4;
			side_s5   <= side_s4;

			// Stage 6
			for (int b = 0; b < 2; b++) begin
				n_s6[b]     <= (135'(nh_s5[b][1]) << 24) + 135'(nh_s5[b][0]);
				d_s6[b]     <= d_s5[b];
				slmag_s6[b] <= slmag_s5[b];
				slneg_s6[b] <= slneg_s5[b];
			end
			spring_s6 <= spring_s5;
			spneg_s6  <= spneg_s5;
			side_s6   <= side_s5;
		end
	end

	// ------------------------------------------------------------------
	// Divider lanes. The magnetic term is C*i^2*2^8 / (y^2*m), the coupling
	// term is kc*(y2-y1) / m, the slope is (V*2^24 - R*i) / L. Each lane works
	// on magnitudes and the sign is restored afterwards, which truncates toward
	// zero. A quotient beyond 75 bits saturates every result it feeds.
	// ------------------------------------------------------------------
	dmd_pkg::div_req_t dreq_w [dmd_pkg::LANES];
	dmd_pkg::div_res_t dres_w [dmd_pkg::LANES];
	dmd_pkg::side_t    dside_w;

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			dreq_w[dmd_pkg::LANE_MAG + b].neg = 1'b0;
			dreq_w[dmd_pkg::LANE_MAG + b].num = {n_s6[b], 8'd0};
			dreq_w[dmd_pkg::LANE_MAG + b].den = d_s6[b];
			dreq_w[dmd_pkg::LANE_CPL + b].neg = spneg_s6;
			dreq_w[dmd_pkg::LANE_CPL + b].num = dmd_pkg::NUM_W'(spring_s6);
			dreq_w[dmd_pkg::LANE_CPL + b].den = dmd_pkg::DEN_W'(mass_eff[b]);
			dreq_w[dmd_pkg::LANE_SLP + b].neg = slneg_s6[b];
			dreq_w[dmd_pkg::LANE_SLP + b].num = dmd_pkg::NUM_W'(slmag_s6[b]);
			dreq_w[dmd_pkg::LANE_SLP + b].den = dmd_pkg::DEN_W'(ind_eff);
		end
	end

	dmd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.adv      (adv),
		.in_valid (vld_s6),
		.in_req   (dreq_w),
		.in_side  (side_s6),
		.out_valid(div_vld),
		.out_res  (dres_w),
		.out_side (dside_w)
	);

	// ------------------------------------------------------------------
	// Stage 7: signed quotients. Stage 8: accelerations. Stage 9: saturation
	// into the output register.
	// ------------------------------------------------------------------
	logic signed [75:0] val_s7 [dmd_pkg::LANES];
	dmd_pkg::side_t     side_s7;
	logic signed [77:0] acc_s8 [2];
	logic signed [75:0] slp_s8 [2];
	dmd_pkg::side_t     side_s8;
	out_t               out_s9;
	logic [48:0]        sat_acc_w [2];
	logic [48:0]        sat_slp_w [2];

	always_comb begin
		for (int b = 0; b < 2; b++) begin
			sat_acc_w[b] = sat_w(acc_s8[b]);
			sat_slp_w[b] = sat_w(78'(slp_s8[b]));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s7 <= 1'b0;
			vld_s8 <= 1'b0;
			vld_s9 <= 1'b0;
		end else if (adv) begin
			vld_s7 <= div_vld;
			vld_s8 <= vld_s7;
			vld_s9 <= vld_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			for (int l = 0; l < dmd_pkg::LANES; l++) begin
				if (dres_w[l].ovf) begin
					val_s7[l] <= dres_w[l].neg ? -$signed({1'b0, {75{1'b1}}})
						: $signed({1'b0, {75{1'b1}}});
				end else begin
					val_s7[l] <= dres_w[l].neg ? -$signed({1'b0, dres_w[l].quo})
						: $signed({1'b0, dres_w[l].quo});
				end
			end
			side_s7 <= dside_w;

			// Ball one: g - magnet - coupling; ball two: g - magnet + coupling.
			acc_s8[0] <= 78'(gravity_q) - 78'(val_s7[dmd_pkg::LANE_MAG])
				- 78'(val_s7[dmd_pkg::LANE_CPL]);
			acc_s8[1] <= 78'(gravity_q) - 78'(val_s7[dmd_pkg::LANE_MAG + 1])
				+ 78'(val_s7[dmd_pkg::LANE_CPL + 1]);
			slp_s8[0] <= val_s7[dmd_pkg::LANE_SLP];
			slp_s8[1] <= val_s7[dmd_pkg::LANE_SLP + 1];
			side_s8   <= side_s7;

			out_s9.pad              <= '0;
			out_s9.rate_gap_one     <= side_s8.spd_one;
			out_s9.accel_one        <= sat_acc_w[0][47:0];
			out_s9.rate_current_one <= sat_slp_w[0][47:0];
			out_s9.rate_gap_two     <= side_s8.spd_two;
			out_s9.accel_two        <= sat_acc_w[1][47:0];
			out_s9.rate_current_two <= sat_slp_w[1][47:0];
			out_s9.clipped          <= sat_acc_w[0][48] | sat_acc_w[1][48]
				| sat_slp_w[0][48] | sat_slp_w[1][48];
		end
	end

	assign m_tvalid = vld_s9;
	assign m_tdata  = out_s9;

endmodule
